FILE: design/pbd_pkg.sv
// Shared types and constants for the PackBits bitmap line decoder.
// Used by pbd_front, pbd_queue, pbd_back and the top level; no dependencies.
`default_nettype none

package pbd_pkg;

  // Scanline geometry and header sizes
  localparam int LINE_BYTES_DEFAULT = 72;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int HDR_POS_W = 10;
  localparam logic [HDR_POS_W-1:0] HDR_SHORT = 10'd512;
  localparam logic [HDR_POS_W-1:0] HDR_LONG  = 10'd640;

  // Configuration
  localparam int LINES_W = 11;
  localparam logic [LINES_W-1:0] IMAGE_LINES_RESET = 11'd720;
  localparam logic [LINES_W-1:0] MAX_LINES = 11'd1024;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int LINE_W = 10;
  localparam int COL_W = 7;
  localparam int STATUS_W = 2;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 3;

  // Input item kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_EOS  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERRUN   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd2;

  typedef struct packed {
    logic              eos;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   value;
    logic [BYTE_W-1:0]   rep;
    logic [LINE_W-1:0]   line;
    logic [COL_W-1:0]    col;
    logic                lend;
    logic                iend;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef enum logic [4:0] {
    PH_CONTROL = 5'b00001,
    PH_LITERAL = 5'b00010,
    PH_REPEAT  = 5'b00100,
    PH_DONE    = 5'b01000,
    PH_ERROR   = 5'b10000
  } phase_t;

endpackage

`default_nettype wire

FILE: design/pbd_front.sv
// Front end: accepts stream items, skips the file header, forwards body items.
// Depends on pbd_pkg; feeds pbd_queue.
`default_nettype none

module pbd_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [pbd_pkg::BYTE_W-1:0]  s_axis_tdata,   // in_byte
  input  wire logic                        s_axis_tuser,   // req_type
  output logic                             q_push,
  output pbd_pkg::item_t                   q_item,
  input  wire logic                        q_full
);

  logic [pbd_pkg::HDR_POS_W-1:0] hdr_pos;
  logic [pbd_pkg::HDR_POS_W-1:0] hdr_pos_next;
  logic                          long_hdr;
  logic                          long_hdr_next;
  logic                          in_body;
  logic                          accept;
  logic                          is_eos;
  logic                          hdr_byte;

  assign s_axis_tready = !q_full;
  assign accept = s_axis_tvalid && !q_full;
  assign is_eos = (s_axis_tuser == pbd_pkg::REQ_EOS);
  assign hdr_byte = !in_body && !is_eos;

  // Drop header bytes; end-of-stream markers always go on to the decoder.
  assign q_push = accept && !hdr_byte;
  assign q_item.eos = is_eos;
  assign q_item.data = s_axis_tdata;

  always_comb begin
    long_hdr_next = long_hdr;
    if (hdr_pos == pbd_pkg::HDR_POS_W'(1)) begin
      long_hdr_next = (s_axis_tdata != '0);
    end
    hdr_pos_next = hdr_pos + pbd_pkg::HDR_POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos <= '0;
      long_hdr <= 1'b0;
      in_body <= 1'b0;
    end else if (accept && hdr_byte) begin
      hdr_pos <= hdr_pos_next;
      long_hdr <= long_hdr_next;
      if (hdr_pos_next >= (long_hdr_next ? pbd_pkg::HDR_LONG : pbd_pkg::HDR_SHORT)) begin
        in_body <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/pbd_queue.sv
// Short FIFO between the front end and the decoder back end.
// Depends on pbd_pkg for the item type.
`default_nettype none

module pbd_queue #(
  parameter int DEPTH = pbd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire pbd_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output pbd_pkg::item_t      pop_item,
  output logic                empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pbd_pkg::item_t  slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign pop_item = slots[rd_ptr];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) r = '0;
    else r = p + PW'(1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wrap_inc(wr_ptr);
      if (pop) rd_ptr <= wrap_inc(rd_ptr);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

`default_nettype wire

FILE: design/pbd_back.sv
// Back end: PackBits run decoder with line/column tracking and an output register.
// Depends on pbd_pkg; consumes items from pbd_queue.
`default_nettype none

module pbd_back #(
  parameter int LINE_BYTES = pbd_pkg::LINE_BYTES_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [pbd_pkg::LINES_W-1:0]     image_lines,
  input  wire logic                            q_empty,
  input  wire pbd_pkg::item_t                  q_item,
  output logic                                 q_pop,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata: out_value[7:0], repeat_count[15:8], line_index[25:16], column[32:26], zero pad
  output logic [pbd_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // tuser: line_end[0], status[2:1]
  output logic [pbd_pkg::OUT_USER_W-1:0]       m_axis_tuser,
  output logic                                 m_axis_tlast    // image_end
);

  localparam logic [7:0] LB = 8'(LINE_BYTES);

  pbd_pkg::phase_t                  phase;
  pbd_pkg::phase_t                  phase_next;
  logic [7:0]                       literal_left;
  logic [7:0]                       literal_left_next;
  logic [7:0]                       pending_repeat;
  logic [7:0]                       pending_repeat_next;
  logic [pbd_pkg::COL_W-1:0]        column_position;
  logic [pbd_pkg::COL_W-1:0]        column_position_next;
  logic [pbd_pkg::LINE_W-1:0]       line_counter;
  logic [pbd_pkg::LINE_W-1:0]       line_counter_next;
  pbd_pkg::result_t                 res;
  pbd_pkg::result_t                 res_next;
  logic                             emit;

  logic [pbd_pkg::LINES_W-1:0]      eff_lines;
  logic [7:0]                       remain;
  logic [7:0]                       run_len;
  logic [8:0]                       col_sum;
  logic                             at_line_end;
  logic                             last_line;
  logic [7:0]                       ctrl_count;

  assign q_pop = !q_empty && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    if (image_lines == '0) eff_lines = pbd_pkg::LINES_W'(1);
    else if (image_lines > pbd_pkg::MAX_LINES) eff_lines = pbd_pkg::MAX_LINES;
    else eff_lines = image_lines;
  end

  assign remain = LB - {1'b0, column_position};
  assign run_len = (phase == pbd_pkg::PH_LITERAL) ? 8'd1 : pending_repeat;
  assign col_sum = {2'b00, column_position} + {1'b0, run_len};
  assign at_line_end = (col_sum >= {1'b0, LB});
  assign last_line = (({1'b0, line_counter} + pbd_pkg::LINES_W'(1)) >= eff_lines);
  // Repeat control gives (1 - c) mod 256; literal control gives c + 1.
  assign ctrl_count = q_item.data[7] ? (8'd1 - q_item.data) : (q_item.data + 8'd1);

  always_comb begin
    phase_next = phase;
    literal_left_next = literal_left;
    pending_repeat_next = pending_repeat;
    column_position_next = column_position;
    line_counter_next = line_counter;
    emit = 1'b0;
    res_next = '0;
    res_next.line = line_counter;
    res_next.col = column_position;
    res_next.status = pbd_pkg::ST_OK;
    if (q_pop) begin
      unique case (phase)
        pbd_pkg::PH_CONTROL: begin
          if (q_item.eos) begin
            emit = 1'b1;
            res_next.status = pbd_pkg::ST_TRUNCATED;
            phase_next = pbd_pkg::PH_ERROR;
          end else if (ctrl_count > remain) begin
            emit = 1'b1;
            res_next.status = pbd_pkg::ST_OVERRUN;
            phase_next = pbd_pkg::PH_ERROR;
          end else if (q_item.data[7]) begin
            pending_repeat_next = ctrl_count;
            phase_next = pbd_pkg::PH_REPEAT;
          end else begin
            literal_left_next = ctrl_count;
            phase_next = pbd_pkg::PH_LITERAL;
          end
        end
        pbd_pkg::PH_LITERAL, pbd_pkg::PH_REPEAT: begin
          emit = 1'b1;
          if (q_item.eos) begin
            res_next.status = pbd_pkg::ST_TRUNCATED;
            phase_next = pbd_pkg::PH_ERROR;
          end else begin
            res_next.value = q_item.data;
            res_next.rep = run_len;
            res_next.lend = at_line_end;
            res_next.iend = at_line_end && last_line;
            if (phase == pbd_pkg::PH_LITERAL) begin
              literal_left_next = literal_left - 8'd1;
            end else begin
              pending_repeat_next = '0;
            end
            column_position_next = at_line_end ? '0 : col_sum[pbd_pkg::COL_W-1:0];
            if (at_line_end && !last_line) begin
              line_counter_next = line_counter + pbd_pkg::LINE_W'(1);
            end
            if (at_line_end && last_line) begin
              phase_next = pbd_pkg::PH_DONE;
            end else if (phase == pbd_pkg::PH_LITERAL && literal_left_next != '0) begin
              phase_next = pbd_pkg::PH_LITERAL;
            end else begin
              phase_next = pbd_pkg::PH_CONTROL;
            end
          end
        end
        default: begin
          // done or error: drop everything until reset
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pbd_pkg::PH_CONTROL;
      literal_left <= '0;
      pending_repeat <= '0;
      column_position <= '0;
      line_counter <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      phase <= phase_next;
      literal_left <= literal_left_next;
      pending_repeat <= pending_repeat_next;
      column_position <= column_position_next;
      line_counter <= line_counter_next;
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_next;
    end
  end

  assign m_axis_tdata = {7'b0000000, res.col, res.line, res.rep, res.value};
  assign m_axis_tuser = {res.status, res.lend};
  assign m_axis_tlast = res.iend;

endmodule

`default_nettype wire

FILE: design/packbits_bitmap_line_decoder.sv
// PackBits bitmap line decoder, top level.
// Depends on pbd_pkg, pbd_front, pbd_queue and pbd_back.
//
// Usage:
//   Feed the raw file bytes from offset zero on the s_axis channel, one item a
//   cycle (tuser 0 = byte in tdata, tuser 1 = end-of-stream marker). The 512 or
//   640 byte header is dropped in the front end; body bytes pass through a
//   short queue to the run decoder. Each literal byte or repeat run comes out
//   as one m_axis item with its byte, count, line and starting column; tuser
//   carries the line-end flag and the status, tlast marks the end of the image.
//   An overrun or a marker before the image is complete gives one error item
//   and the decoder then drops all input until reset, as it does after tlast.
//   A body byte is written into the queue when accepted; the decoder step that pops it
//   loads the output register. Throughput: one item per cycle while m_axis_tready is
//   high, set by the single decoder step per queued item; control and header bytes give
//   no output. When m_axis_tready is low the output register holds, the queue fills, and
//   s_axis_tready drops once the queue is full. cfg_data (image_lines) is to be written
//   on cfg_valid while idle, a user rule the block does not enforce; cfg_ready is high.
//   Reset (rst, synchronous) clears all decoder state and sets image_lines to 720.
`default_nettype none

module packbits_bitmap_line_decoder #(
  parameter int LINE_BYTES = pbd_pkg::LINE_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH = pbd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pbd_pkg::LINES_W-1:0]     cfg_data,       // image_lines
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [pbd_pkg::BYTE_W-1:0]      s_axis_tdata,   // in_byte[7:0]
  input  wire logic                            s_axis_tuser,   // req_type[0]
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata: out_value[7:0], repeat_count[15:8], line_index[25:16], column[32:26], zero pad
  output logic [pbd_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // tuser: line_end[0], status[2:1]
  output logic [pbd_pkg::OUT_USER_W-1:0]       m_axis_tuser,
  output logic                                 m_axis_tlast    // image_end
);

  logic [pbd_pkg::LINES_W-1:0] image_lines;
  logic                        q_push;
  logic                        q_full;
  logic                        q_pop;
  logic                        q_empty;
  pbd_pkg::item_t              q_in_item;
  pbd_pkg::item_t              q_out_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_lines <= pbd_pkg::IMAGE_LINES_RESET;
    end else if (cfg_valid) begin
      image_lines <= cfg_data;
    end
  end

  pbd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_push        (q_push),
    .q_item        (q_in_item),
    .q_full        (q_full)
  );

  pbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .empty     (q_empty)
  );

  pbd_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .image_lines   (image_lines),
    .q_empty       (q_empty),
    .q_item        (q_out_item),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Error items carry no run.
  a_err_no_run: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2:1] != pbd_pkg::ST_OK) |->
      (m_axis_tdata[15:8] == '0 && !m_axis_tlast && !m_axis_tuser[0]))
    else $error("error item carries run data");

  // The image ends only at a line end.
  a_iend_lend: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
    else $error("image end without line end");

  // Runs start inside the line.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[32:26] < pbd_pkg::COL_W'(LINE_BYTES)))
    else $error("run column outside the line");

  // Nothing follows the last item of the image.
  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("result after image end");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for packbits_bitmap_line_decoder: feeds a bitmap file
// stream (header, directed runs, random PackBits runs) and checks every run item.
// Depends on pbd_pkg and the decoder RTL only.
`default_nettype none

module tb;

  localparam int ROW_BYTES = pbd_pkg::LINE_BYTES_DEFAULT;

  // Predicts the run items of the decoder and checks them in order.
  class run_scoreboard;
    logic [pbd_pkg::LINES_W-1:0] lines;
    bit hdr_active;
    bit long_hdr;
    int hdr_pos;
    pbd_pkg::phase_t ph;
    int lit_left;
    int rep_pending;
    int col;
    int line_cnt;
    pbd_pkg::result_t runs_due[$];
    int checked;
    int errors;

    function new();
      lines = pbd_pkg::IMAGE_LINES_RESET;
      hdr_active = 1'b1;
      long_hdr = 1'b0;
      hdr_pos = 0;
      ph = pbd_pkg::PH_CONTROL;
      lit_left = 0;
      rep_pending = 0;
      col = 0;
      line_cnt = 0;
      checked = 0;
      errors = 0;
    endfunction

    function int lines_in_image();
      if (lines == 0) return 1;
      if (lines > pbd_pkg::MAX_LINES) return int'(pbd_pkg::MAX_LINES);
      return int'(lines);
    endfunction

    function bit halted();
      return (ph == pbd_pkg::PH_DONE) || (ph == pbd_pkg::PH_ERROR);
    endfunction

    function int pending();
      return runs_due.size();
    endfunction

    function void push_run(logic [pbd_pkg::BYTE_W-1:0] value, int n);
      pbd_pkg::result_t r;
      r = '0;
      r.value = value;
      r.rep = pbd_pkg::BYTE_W'(n);
      r.line = pbd_pkg::LINE_W'(line_cnt);
      r.col = pbd_pkg::COL_W'(col);
      col += n;
      if (col >= ROW_BYTES) begin
        r.lend = 1'b1;
        col = 0;
        if (line_cnt + 1 >= lines_in_image()) begin
          r.iend = 1'b1;
          ph = pbd_pkg::PH_DONE;
        end else begin
          line_cnt++;
        end
      end
      runs_due.push_back(r);
    endfunction

    function void stop_on(logic [pbd_pkg::STATUS_W-1:0] st);
      pbd_pkg::result_t r;
      r = '0;
      r.line = pbd_pkg::LINE_W'(line_cnt);
      r.col = pbd_pkg::COL_W'(col);
      r.status = st;
      ph = pbd_pkg::PH_ERROR;
      runs_due.push_back(r);
    endfunction

    function void note_item(logic eos, logic [pbd_pkg::BYTE_W-1:0] b);
      int v;
      int cnt;
      v = int'(b);
      if (halted()) return;
      if (eos == pbd_pkg::REQ_EOS) begin
        stop_on(pbd_pkg::ST_TRUNCATED);
        return;
      end
      if (hdr_active) begin
        if (hdr_pos == 1) long_hdr = (b != 0);
        hdr_pos++;
        if (hdr_pos >= (long_hdr ? pbd_pkg::HDR_LONG : pbd_pkg::HDR_SHORT)) hdr_active = 1'b0;
        return;
      end
      case (ph)
        pbd_pkg::PH_CONTROL: begin
          cnt = b[7] ? 257 - v : v + 1;
          if (cnt > ROW_BYTES - col) begin
            stop_on(pbd_pkg::ST_OVERRUN);
          end else if (b[7]) begin
            rep_pending = cnt;
            ph = pbd_pkg::PH_REPEAT;
          end else begin
            lit_left = cnt;
            ph = pbd_pkg::PH_LITERAL;
          end
        end
        pbd_pkg::PH_LITERAL: begin
          lit_left--;
          ph = pbd_pkg::PH_CONTROL;
          push_run(b, 1);
          if (ph == pbd_pkg::PH_CONTROL && lit_left != 0) ph = pbd_pkg::PH_LITERAL;
        end
        default: begin
          ph = pbd_pkg::PH_CONTROL;
          push_run(b, rep_pending);
          rep_pending = 0;
        end
      endcase
    endfunction

    function void check_result(pbd_pkg::result_t got);
      pbd_pkg::result_t want;
      checked++;
      if (runs_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected run item value %02h rep %0d line %0d col %0d status %0d",
                   $time, got.value, got.rep, got.line, got.col, got.status);
        return;
      end
      want = runs_due.pop_front();
      if (got.value !== want.value || got.rep !== want.rep || got.line !== want.line ||
          got.col !== want.col || got.lend !== want.lend || got.iend !== want.iend ||
          got.status !== want.status) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch, expected value %02h rep %0d line %0d col %0d lend %0b iend %0b st %0d",
                   $time, want.value, want.rep, want.line, want.col, want.lend, want.iend,
                   want.status);
          $display("%0t:           got value %02h rep %0d line %0d col %0d lend %0b iend %0b st %0d",
                   $time, got.value, got.rep, got.line, got.col, got.lend, got.iend,
                   got.status);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [pbd_pkg::LINES_W-1:0] cfg_data;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [pbd_pkg::BYTE_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [pbd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [pbd_pkg::OUT_USER_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  run_scoreboard sb;
  int send_pct;
  int recv_pct;
  int items_sent;
  int mid_lines;
  int last_lines;
  string ending;

  packbits_bitmap_line_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_pct);
  end

  // Unpack each accepted run item and hand it to the scoreboard.
  always @(posedge clk) begin
    pbd_pkg::result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.value = m_axis_tdata[7:0];
      got.rep = m_axis_tdata[15:8];
      got.line = m_axis_tdata[25:16];
      got.col = m_axis_tdata[32:26];
      got.lend = m_axis_tuser[0];
      got.status = m_axis_tuser[2:1];
      got.iend = m_axis_tlast;
      sb.check_result(got);
    end
  end

  function automatic logic [pbd_pkg::BYTE_W-1:0] rand_byte();
    return pbd_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  // Returns at the edge where the item is taken.
  task automatic send_item(input logic eos, input logic [pbd_pkg::BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < send_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= eos;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(eos, b);
    items_sent++;
  endtask

  task automatic write_lines(input logic [pbd_pkg::LINES_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.lines = v;
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, drain every outstanding run item, then let the pipeline empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // One well-formed run that fits in what is left of the line.
  task automatic send_run();
    int remain;
    int n;
    int pick;
    remain = ROW_BYTES - sb.col;
    pick = $urandom_range(0, 9);
    if (pick < 2) n = remain;
    else if (pick == 2) n = $urandom_range(1, remain);
    else n = $urandom_range(1, remain < 8 ? remain : 8);
    if (n == 1 || $urandom_range(0, 1) == 1) begin
      send_item(pbd_pkg::REQ_BYTE, pbd_pkg::BYTE_W'(n - 1));
      repeat (n) send_item(pbd_pkg::REQ_BYTE, rand_byte());
    end else begin
      send_item(pbd_pkg::REQ_BYTE, pbd_pkg::BYTE_W'(257 - n));
      send_item(pbd_pkg::REQ_BYTE, rand_byte());
    end
  endtask

  initial begin
    int hdr_len;
    int remain;
    int sel;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= pbd_pkg::REQ_BYTE;
    send_pct = 36;
    recv_pct = 79;
    items_sent = 0;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out-of-range line count clamps to the maximum.
    write_lines(11'd2047);

    // File header: byte 1 selects the long form.
    hdr_len = ($urandom_range(0, 1) == 1) ? int'(pbd_pkg::HDR_LONG) : int'(pbd_pkg::HDR_SHORT);
    for (int i = 0; i < hdr_len; i++) begin
      if (i == 1)
        send_item(pbd_pkg::REQ_BYTE, (hdr_len == pbd_pkg::HDR_LONG) ?
                  pbd_pkg::BYTE_W'($urandom_range(1, 255)) : 8'h00);
      else send_item(pbd_pkg::REQ_BYTE, rand_byte());
    end

    // Directed lines: long repeat plus short literal, full-line repeat,
    // shortest repeat, single literal and a repeat that lands on the line end.
    send_item(pbd_pkg::REQ_BYTE, 8'hBB);
    send_item(pbd_pkg::REQ_BYTE, 8'hFF);
    send_item(pbd_pkg::REQ_BYTE, 8'h01);
    send_item(pbd_pkg::REQ_BYTE, 8'h00);
    send_item(pbd_pkg::REQ_BYTE, 8'hA5);
    send_item(pbd_pkg::REQ_BYTE, 8'hB9);
    send_item(pbd_pkg::REQ_BYTE, 8'h00);
    send_item(pbd_pkg::REQ_BYTE, 8'hFF);
    send_item(pbd_pkg::REQ_BYTE, 8'h5A);
    send_item(pbd_pkg::REQ_BYTE, 8'h00);
    send_item(pbd_pkg::REQ_BYTE, 8'hFF);
    send_item(pbd_pkg::REQ_BYTE, 8'hBC);
    send_item(pbd_pkg::REQ_BYTE, 8'h80);

    while (items_sent < hdr_len + 330 && !sb.halted()) send_run();
    settle();

    send_pct = 79;
    recv_pct = 36;
    mid_lines = $urandom_range(sb.line_cnt + 500, pbd_pkg::MAX_LINES);
    write_lines(pbd_pkg::LINES_W'(mid_lines));
    while (items_sent < hdr_len + 660 && !sb.halted()) send_run();
    settle();

    send_pct = 0;
    recv_pct = 0;
    write_lines(pbd_pkg::MAX_LINES);
    while (items_sent < hdr_len + 980 && !sb.halted()) send_run();
    settle();

    // Finish the image, overrun a line, or cut the stream short.
    last_lines = int'(pbd_pkg::MAX_LINES);
    ending = "early image end";
    if (!sb.halted()) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          sel = $urandom_range(0, 3);
          if (sel == 0) last_lines = 0;
          else if (sel == 1) last_lines = 1;
          else if (sel == 2) last_lines = sb.line_cnt + 1;
          else last_lines = $urandom_range(1, sb.line_cnt + 1);
          write_lines(pbd_pkg::LINES_W'(last_lines));
          while (!sb.halted()) send_run();
          ending = "image end after lowering the line count";
        end
        2: begin
          remain = ROW_BYTES - sb.col;
          sel = $urandom_range(0, 3);
          if (sel == 0) send_item(pbd_pkg::REQ_BYTE, 8'h80);
          else if (sel == 1) send_item(pbd_pkg::REQ_BYTE, 8'h7F);
          else if (sel == 2) send_item(pbd_pkg::REQ_BYTE, pbd_pkg::BYTE_W'(remain));
          else send_item(pbd_pkg::REQ_BYTE, pbd_pkg::BYTE_W'(256 - remain));
          ending = "line overrun";
        end
        default: begin
          if ($urandom_range(0, 1) == 1) send_item(pbd_pkg::REQ_BYTE, 8'h00);
          send_item(pbd_pkg::REQ_EOS, rand_byte());
          ending = "truncated stream";
        end
      endcase
    end

    // Everything after the image or an error must be swallowed silently.
    for (int i = 0; i < 16; i++)
      send_item((i % 2 == 1) ? pbd_pkg::REQ_EOS : pbd_pkg::REQ_BYTE, rand_byte());
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d run items from %0d input items, %0d-byte header, %0d lines reached",
             sb.checked, items_sent, hdr_len, sb.line_cnt + 1);
    $display("Line counts 2047, %0d, 1024 and %0d; run ended on %0s",
             mid_lines, last_lines, ending);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d run items still outstanding", sb.errors, sb.pending());
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timed out waiting for the decoder");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
design/pbd_pkg.sv
design/pbd_front.sv
design/pbd_queue.sv
design/pbd_back.sv
design/packbits_bitmap_line_decoder.sv
bench/tb.sv
